// File: rtl/hrp_pkg.sv
package hrp_pkg;

    // ASCII characters of the record format
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] HEX_DIGIT_BASE = 8'h30;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

    // control record fields
    localparam logic [7:0] TAG_HEADER     = 8'h01;
    localparam logic [7:0] TAG_END        = 8'h05;
    localparam logic [7:0] CTRL_FIELD_ONE = 8'h01;
    localparam int         CTRL_LEN       = 13;

    localparam logic [2:0] REC_TYPE_RESET = 3'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [31:0] ascii_chars;
        logic [2:0]  char_count;
        logic        end_of_run;
    } t_out_item;

    // upper-case hex character of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return HEX_DIGIT_BASE + 8'(nib);
        end
        return HEX_ALPHA_BASE + 8'(nib);
    endfunction

endpackage

// File: rtl/hrp_stream_if.sv
interface hrp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/hex_record_packer.sv
// Characters are packed four to an output beat in a registered output; one character is
//   produced per cycle, except while a full beat waits on output back-pressure.
// A quiet byte is only stored; a header or end record has 13 characters, a data record
//   9 characters plus 2 per stored byte, and a deferred byte is stored in S_STORE.
// Reset (synchronous, active low): clears fill count, byte sum, header flag and packer; the
//   record type returns to 2. Record store contents stay undefined; no clearing pass.
module hex_record_packer
    import hrp_pkg::*;
#(
    parameter int RECORD_BYTES = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [2:0]          i_cfg_wr_data,
    hrp_stream_if.sink          i_in,
    hrp_stream_if.source        o_out
);

    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;   // store address
    localparam int FW = $clog2(RECORD_BYTES + 1);                        // fill count
    localparam int PW = $clog2(2 * RECORD_BYTES + 10);                   // char position
    localparam int PAIR_W = PW - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_DAT,
        S_STORE,
        S_END
    } t_state;

    // record store: one byte per entry, synchronous read with registered data
    logic [7:0]     r_store [RECORD_BYTES];
    logic [7:0]     r_rd;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;

    t_state         r_state, n_state;
    logic [PW-1:0]  r_pos, n_pos;
    logic [FW-1:0]  r_fill, n_fill;
    logic [7:0]     r_sum, n_sum;
    logic           r_hdr_sent, n_hdr_sent;
    logic           r_flush, n_flush;
    logic           r_last, n_last;
    logic [7:0]     r_pend, n_pend;
    logic [AW-1:0]  r_idx, n_idx;
    logic [2:0]     r_rec_type;
    logic [23:0]    r_acc, n_acc;
    logic [1:0]     r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;
    t_out_item      r_out, n_out;

    // character generation
    logic              is_ctrl;
    logic              char_on;
    logic [7:0]        tag;
    logic [7:0]        ctrl_ck;
    logic [7:0]        data_ck;
    logic [PW-1:0]     data_end;
    logic [PW-1:0]     rec_len;
    logic [PW-1:0]     pos_m1;
    logic [PAIR_W-1:0] pair_sel;
    logic [7:0]        pair_byte;
    logic [7:0]        ch;
    logic              is_lf;
    logic              final_char;
    logic              word_done;
    logic              can_push;
    logic              emit;
    logic              in_acc;
    logic              flush_now;

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign in_acc    = i_in.valid && (r_state == S_IDLE);
    assign flush_now = (r_fill == FW'(RECORD_BYTES));

    assign is_ctrl  = (r_state == S_HDR) || (r_state == S_END);
    assign char_on  = is_ctrl || (r_state == S_DAT);
    assign tag      = (r_state == S_HDR) ? TAG_HEADER : TAG_END;
    assign ctrl_ck  = 8'd0 - (tag + CTRL_FIELD_ONE);
    assign data_ck  = 8'd0 - (8'(r_rec_type) + 8'(r_fill) + r_sum);
    assign data_end = PW'(5) + PW'({r_fill, 1'b0});
    assign rec_len  = is_ctrl ? PW'(CTRL_LEN) : (data_end + PW'(4));
    assign pos_m1   = r_pos - PW'(1);
    assign pair_sel = pos_m1[PW-1:1];
    assign is_lf    = (r_pos == rec_len - PW'(1));

    // select the byte whose hex pair covers the current position
    always_comb begin
        pair_byte = 8'd0;
        if (is_ctrl) begin
            case (pair_sel)
                PAIR_W'(0): pair_byte = tag;
                PAIR_W'(1): pair_byte = 8'd0;
                PAIR_W'(2): pair_byte = 8'(r_rec_type);
                PAIR_W'(3): pair_byte = CTRL_FIELD_ONE;
                default:    pair_byte = ctrl_ck;
            endcase
        end else if (pair_sel == PAIR_W'(0)) begin
            pair_byte = 8'(r_rec_type);
        end else if (pair_sel == PAIR_W'(1)) begin
            pair_byte = 8'(r_fill);
        end else if (r_pos < data_end) begin
            pair_byte = r_rd;
        end else begin
            pair_byte = data_ck;
        end
    end

    // odd positions carry the high nibble of a pair
    always_comb begin
        if (r_pos == PW'(0)) begin
            ch = CHAR_COLON;
        end else if (r_pos == rec_len - PW'(2)) begin
            ch = CHAR_CR;
        end else if (is_lf) begin
            ch = CHAR_LF;
        end else if (r_pos[0]) begin
            ch = hex_char(pair_byte[7:4]);
        end else begin
            ch = hex_char(pair_byte[3:0]);
        end
    end

    // last character of the item's stream closes the run
    assign final_char = is_lf && (((r_state == S_HDR) && !r_flush && !r_last) ||
                                  ((r_state == S_DAT) && r_flush && !r_last) ||
                                  (r_state == S_END));
    assign word_done  = (r_cnt == 2'd3) || final_char;
    assign can_push   = !r_out_valid || o_out.ready;
    assign emit       = char_on && (!word_done || can_push);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_hdr_sent  = r_hdr_sent;
        n_flush     = r_flush;
        n_last      = r_last;
        n_pend      = r_pend;
        n_idx       = r_idx;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = r_fill[AW-1:0];
        mem_wdata   = i_in.payload.data_byte;
        rd_en       = 1'b0;
        rd_addr     = r_idx + AW'(1);

        // pack characters into output beats
        if (emit) begin
            if (word_done) begin
                n_out_valid       = 1'b1;
                n_out.ascii_chars = 32'(r_acc) | (32'(ch) << {r_cnt, 3'b000});
                n_out.char_count  = 3'(r_cnt) + 3'd1;
                n_out.end_of_run  = final_char;
                n_acc             = 24'd0;
                n_cnt             = 2'd0;
            end else begin
                n_acc = r_acc | (24'(ch) << {r_cnt, 3'b000});
                n_cnt = r_cnt + 2'd1;
            end
            n_pos = is_lf ? PW'(0) : r_pos + PW'(1);
        end

        // prefetch store bytes: entry 0 at the colon, the next entry at each data low nibble but the last
        if (emit && (r_state == S_DAT)) begin
            if (r_pos == PW'(0)) begin
                rd_en   = 1'b1;
                rd_addr = AW'(0);
                n_idx   = AW'(0);
            end else if (!r_pos[0] && (r_pos > PW'(5)) && (r_pos < data_end) &&
                         (r_pos + PW'(1) != data_end)) begin
                rd_en = 1'b1;
                n_idx = r_idx + AW'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last  = i_in.payload.last_byte;
                    n_flush = flush_now;
                    n_pos   = PW'(0);
                    if (flush_now) begin
                        n_pend = i_in.payload.data_byte;
                    end else begin
                        mem_we = 1'b1;
                        n_fill = r_fill + FW'(1);
                        n_sum  = r_sum + i_in.payload.data_byte;
                    end
                    if (!r_hdr_sent) begin
                        n_state = S_HDR;
                    end else if (flush_now || i_in.payload.last_byte) begin
                        n_state = S_DAT;
                    end
                end
            end
            S_HDR: begin
                if (emit && is_lf) begin
                    n_hdr_sent = 1'b1;
                    n_state    = (r_flush || r_last) ? S_DAT : S_IDLE;
                end
            end
            S_DAT: begin
                if (emit && is_lf) begin
                    n_fill  = '0;
                    n_sum   = 8'd0;
                    n_state = r_flush ? S_STORE : S_END;
                end
            end
            S_STORE: begin
                // write the byte held back while the full record went out
                mem_we    = 1'b1;
                mem_waddr = AW'(0);
                mem_wdata = r_pend;
                n_fill    = FW'(1);
                n_sum     = r_pend;
                n_flush   = 1'b0;
                n_state   = r_last ? S_DAT : S_IDLE;
            end
            S_END: begin
                if (emit && is_lf) begin
                    n_hdr_sent = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_fill      <= '0;
            r_sum       <= 8'd0;
            r_hdr_sent  <= 1'b0;
            r_flush     <= 1'b0;
            r_last      <= 1'b0;
            r_pend      <= 8'd0;
            r_idx       <= '0;
            r_rec_type  <= REC_TYPE_RESET;
            r_acc       <= 24'd0;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_hdr_sent  <= n_hdr_sent;
            r_flush     <= n_flush;
            r_last      <= n_last;
            r_pend      <= n_pend;
            r_idx       <= n_idx;
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
            if (i_cfg_wr_en) begin
                r_rec_type <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= r_store[rd_addr];
        end
    end

    // fill count never passes the record size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(RECORD_BYTES))
        else $error("fill count beyond record size");

    // a short beat only ends a run
    a_short_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.char_count != 3'd4)) |-> r_out.end_of_run)
        else $error("short beat in mid run");

    // store is never written and read in one cycle
    a_mem_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && rd_en))
        else $error("store write and read collide");

    // a quiet byte leaves the block idle
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_hdr_sent && !i_in.payload.last_byte && !flush_now)
            |=> (r_state == S_IDLE))
        else $error("quiet byte started a record");

endmodule

// File: dv/tb_hex_record_packer.sv
module tb_hex_record_packer;
    import hrp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REC_BYTES  = 48;
    localparam int ITEM_GOAL  = 480;
    localparam int MAX_WAIT   = 12;
    // settle time for quiet bytes and deferred stores that finish after the last beat
    localparam int SETTLE_CYC = 10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [2:0] cfg_wr_data;

    hrp_stream_if #(.T(t_in_item))  in_if ();
    hrp_stream_if #(.T(t_out_item)) out_if ();

    hex_record_packer #(
        .RECORD_BYTES (REC_BYTES)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Record encoder predictor: its own copy of the store, fill level,
    // running sum, header flag and record type.
    // ------------------------------------------------------------------
    logic [7:0]  rec_store [REC_BYTES];
    int unsigned rec_fill;
    logic [7:0]  rec_sum;
    bit          hdr_sent;
    logic [2:0]  rec_type;

    logic [7:0]  line_q [$];       // characters one byte causes, in order
    t_out_item   pending_beats [$]; // output beats still owed by the block

    int unsigned bytes_sent;
    int unsigned files_done;
    int unsigned full_flushes;
    int unsigned beats_checked;
    int unsigned mismatches;
    bit [7:0]    types_written;
    bit          src_fast;
    bit          sink_fast;

    function automatic logic [7:0] nibble_char(input logic [3:0] n);
        return (n > 4'd9) ? (8'h41 + 8'(n) - 8'd10) : (8'h30 + 8'(n));
    endfunction

    function automatic void put_hex(input logic [7:0] b);
        line_q.push_back(nibble_char(b[7:4]));
        line_q.push_back(nibble_char(b[3:0]));
    endfunction

    function automatic void put_crlf();
        line_q.push_back(CHAR_CR);
        line_q.push_back(CHAR_LF);
    endfunction

    // header or end record: tag, zero, type, one, check byte
    function automatic void put_control(input logic [7:0] tag);
        line_q.push_back(CHAR_COLON);
        put_hex(tag);
        put_hex(8'h00);
        put_hex({5'b0, rec_type});
        put_hex(CTRL_FIELD_ONE);
        put_hex(8'h00 - (tag + CTRL_FIELD_ONE));
        put_crlf();
    endfunction

    // data record from the store, then start a new record
    function automatic void put_data();
        logic [7:0] ck;
        ck = 8'h00 - ({5'b0, rec_type} + 8'(rec_fill) + rec_sum);
        line_q.push_back(CHAR_COLON);
        put_hex({5'b0, rec_type});
        put_hex(8'(rec_fill));
        for (int i = 0; i < int'(rec_fill); i++) begin
            put_hex(rec_store[i]);
        end
        put_hex(ck);
        put_crlf();
        rec_fill = 0;
        rec_sum  = 8'h00;
    endfunction

    function automatic void predict_byte(input logic [7:0] d, input bit last);
        line_q.delete();
        if (!hdr_sent) begin
            put_control(TAG_HEADER);
            hdr_sent = 1'b1;
        end
        // a full record goes out only once the next byte shows up
        if (rec_fill >= REC_BYTES) begin
            put_data();
            full_flushes++;
        end
        if (rec_fill < REC_BYTES) begin
            rec_store[rec_fill] = d;
            rec_fill++;
            rec_sum = rec_sum + d;
        end
        if (last) begin
            put_data();
            put_control(TAG_END);
            hdr_sent = 1'b0;
            files_done++;
        end
    endfunction

    // cut the character stream into beats of four, end flag on the final one
    function automatic void queue_beats();
        t_out_item   beat;
        int unsigned cnt;
        for (int base = 0; base < line_q.size(); base += 4) begin
            cnt = line_q.size() - base;
            if (cnt > 4) begin
                cnt = 4;
            end
            beat = '0;
            for (int j = 0; j < int'(cnt); j++) begin
                beat.ascii_chars[8*j +: 8] = line_q[base + j];
            end
            beat.char_count = 3'(cnt);
            beat.end_of_run = (base + 4 >= line_q.size());
            pending_beats.push_back(beat);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side. Call right after a rising edge; returns at the edge that
    // takes the beat. Valid stays high when the next byte follows at once.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] d, input bit last);
        int unsigned gap;
        gap = src_fast ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= {d, last};
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        predict_byte(d, last);
        bytes_sent++;
    endtask

    // drop valid, wait for every owed beat, then let the block settle
    task automatic drain_outputs();
        in_if.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_rec_type(input logic [2:0] v);
        drain_outputs();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rec_type = v;
        types_written[v] = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Output side: hold ready low for a random stall per beat, with
    // stretches of full-rate acceptance.
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        int unsigned taken;
        out_if.ready <= 1'b0;
        taken = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            stall = sink_fast ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
            while (!out_if.valid) @(posedge clk);
            taken++;
            if (taken % 40 == 0) begin
                sink_fast = ($urandom_range(0, 3) == 0);
            end
        end
    end

    // compare each accepted beat with the oldest owed one, field by field
    always @(posedge clk) begin
        if (rst_n && out_if.valid && out_if.ready) begin : check_beat
            t_out_item want;
            t_out_item got;
            got = out_if.payload;
            if (pending_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("beat %0d: unexpected, got chars %h count %0d end %0d",
                             beats_checked, got.ascii_chars, got.char_count,
                             got.end_of_run);
                end
            end else begin
                want = pending_beats.pop_front();
                if (got.ascii_chars !== want.ascii_chars ||
                    got.char_count  !== want.char_count  ||
                    got.end_of_run  !== want.end_of_run) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("beat %0d: expected %h/%0d/%0d, got %h/%0d/%0d",
                                 beats_checked, want.ascii_chars, want.char_count,
                                 want.end_of_run, got.ascii_chars, got.char_count,
                                 got.end_of_run);
                    end
                end
            end
            beats_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Directed rows. Typed text is the expected character stream: a space
    // stands for CR LF between records, and CR LF closes the last record.
    // Rows without typed text go through the predictor.
    // ------------------------------------------------------------------
    typedef struct {
        bit         cfg_wr;
        logic [2:0] cfg_val;
        logic [7:0] data;
        bit         last;
        bit         typed;
        string      text;
    } t_dir_row;

    t_dir_row dir_rows [13] = '{
        // type 2 from reset: header only
        '{1'b0, 3'd0, 8'h00, 1'b0, 1'b1, ":01000201FE"},
        // close a two-byte file: data record, end record
        '{1'b0, 3'd0, 8'hFF, 1'b1, 1'b1, ":020200FFFD :05000201FA"},
        // one-byte files of types 4, 0 and 7, covering both ends of the type range
        '{1'b1, 3'd4, 8'hA5, 1'b1, 1'b1, ":01000401FE :0401A556 :05000401FA"},
        '{1'b1, 3'd0, 8'h80, 1'b1, 1'b1, ":01000001FE :0001807F :05000001FA"},
        '{1'b1, 3'd7, 8'h5A, 1'b1, 1'b1, ":01000701FE :07015A9E :05000701FA"},
        '{1'b1, 3'd3, 8'h01, 1'b0, 1'b1, ":01000301FE"},
        // quiet byte: nothing comes out
        '{1'b0, 3'd0, 8'h10, 1'b0, 1'b1, ""},
        // type changes in the middle of a file and between files
        '{1'b1, 3'd5, 8'hC3, 1'b0, 1'b0, ""},
        '{1'b1, 3'd1, 8'h7E, 1'b1, 1'b0, ""},
        '{1'b1, 3'd2, 8'h55, 1'b0, 1'b0, ""},
        '{1'b0, 3'd0, 8'hAA, 1'b0, 1'b0, ""},
        '{1'b0, 3'd0, 8'h0F, 1'b0, 1'b0, ""},
        '{1'b0, 3'd0, 8'hF0, 1'b1, 1'b0, ""}
    };

    initial begin
        int unsigned len;
        int unsigned cut;
        int unsigned sel;
        logic [7:0]  ch;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;

        rec_fill      = 0;
        rec_sum       = 8'h00;
        hdr_sent      = 1'b0;
        rec_type      = REC_TYPE_RESET;
        bytes_sent    = 0;
        files_done    = 0;
        full_flushes  = 0;
        beats_checked = 0;
        mismatches    = 0;
        types_written = '0;
        src_fast      = 1'b0;
        sink_fast     = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: typed rows replace the predicted stream
        foreach (dir_rows[r]) begin
            if (dir_rows[r].cfg_wr) begin
                write_rec_type(dir_rows[r].cfg_val);
            end
            send_byte(dir_rows[r].data, dir_rows[r].last);
            if (dir_rows[r].typed) begin
                line_q.delete();
                for (int i = 0; i < dir_rows[r].text.len(); i++) begin
                    ch = dir_rows[r].text[i];
                    if (ch == " ") begin
                        line_q.push_back(CHAR_CR);
                        line_q.push_back(CHAR_LF);
                    end else begin
                        line_q.push_back(ch);
                    end
                end
                if (dir_rows[r].text.len() != 0) begin
                    line_q.push_back(CHAR_CR);
                    line_q.push_back(CHAR_LF);
                end
            end
            queue_beats();
        end

        // random part: whole files, mostly short, some straddling one or two
        // full records, with type changes between and inside files
        while (bytes_sent < ITEM_GOAL) begin
            sel = $urandom_range(0, 19);
            if (sel < 12) begin
                len = $urandom_range(1, 12);
            end else if (sel < 17) begin
                len = REC_BYTES * $urandom_range(1, 2) + $urandom_range(0, 2) - 1;
            end else begin
                len = $urandom_range(13, 60);
            end
            if ($urandom_range(0, 2) == 0) begin
                write_rec_type(3'($urandom_range(0, 7)));
            end
            cut = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
            src_fast = ($urandom_range(0, 3) == 0);
            for (int unsigned i = 0; i < len; i++) begin
                if (cut != 0 && i == cut) begin
                    write_rec_type(3'($urandom_range(0, 7)));
                end
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
                queue_beats();
            end
        end

        drain_outputs();
        repeat (SETTLE_CYC) @(posedge clk);
        mismatches += pending_beats.size();

        $display("Sent %0d bytes in %0d files, %0d full records flushed by a following byte.",
                 bytes_sent, files_done, full_flushes);
        $display("Checked %0d output beats; file types written: %b.",
                 beats_checked, types_written);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/hrp_pkg.sv
rtl/hrp_stream_if.sv
rtl/hex_record_packer.sv
dv/tb_hex_record_packer.sv
